FILE: hdl/assert_macros.svh
// assertion macros shared by the pool autoscale rtl
// clocked on clk_i and disabled while rst_ni is low; empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/pac_pkg.sv
// shared types and constants of the pool autoscale controller
// no dependencies; imported by every module of the block
`default_nettype none

package pac_pkg;

  // field widths
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned POOL_W  = 16;
  localparam int unsigned UTIL_W  = 7;
  localparam int unsigned STB_W   = 4;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CDATA_W = 16;

  // shared divider sizing: quotient always below 128
  localparam int unsigned DIV_N_W = 23;
  localparam int unsigned DIV_Q_W = 7;

  // arithmetic constants
  localparam int unsigned NS_PER_MS     = 1000000;
  localparam int unsigned PCT           = 100;
  localparam int unsigned STABLE_NEEDED = 3;
  localparam int unsigned STABLE_CAP    = 10;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ENABLED    = 4'd0;
  localparam logic [IDX_W-1:0] REG_MIN_PAGES  = 4'd1;
  localparam logic [IDX_W-1:0] REG_MAX_PAGES  = 4'd2;
  localparam logic [IDX_W-1:0] REG_TARGET     = 4'd3;
  localparam logic [IDX_W-1:0] REG_HIGH_THR   = 4'd4;
  localparam logic [IDX_W-1:0] REG_LOW_THR    = 4'd5;
  localparam logic [IDX_W-1:0] REG_INTERVAL   = 4'd6;
  localparam logic [IDX_W-1:0] REG_EMA_WEIGHT = 4'd7;

  // per-tick result code
  typedef enum logic [2:0] {
    ST_DISABLED  = 3'd0,
    ST_NOT_DUE   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_GREW      = 3'd3,
    ST_SHRANK    = 3'd4
  } status_e;

  // hysteresis decision handed back to the sequencer
  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [STB_W-1:0]  stable;
    status_e           status;
  } resize_t;

endpackage

`default_nettype wire

FILE: hdl/pac_div.sv
// shared restoring divider, one quotient bit per cycle, quotient below 2**DIV_Q_W
// depends on pac_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pac_div import pac_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DIV_N_W-1:0] dividend_i,
  input  wire logic [POOL_W-1:0]  divisor_i,
  output logic                    done_o,
  output logic [DIV_Q_W-1:0]      quot_o
);

  localparam int unsigned STEP_W = $clog2(DIV_Q_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIV_N_W-1:0] rem_q, rem_d;
  logic [POOL_W-1:0]  dvs_q, dvs_d;
  logic [DIV_Q_W-1:0] quot_q, quot_d;
  logic [DIV_N_W-1:0] shifted;
  logic               fits;

  // trial subtract of the shifted divisor
  assign shifted = DIV_N_W'(dvs_q) << step_q;
  assign fits    = (rem_q >= shifted);

  // iteration control and datapath next values
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_Q_W - 1);
      rem_d  = dividend_i;
      dvs_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - shifted;
      end
      quot_d[step_q] = fits;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `ASSERT_IMPLIES(a_div_start_idle, start_i, !busy_q, "divider started while busy")
  `ASSERT_ALWAYS(a_div_busy_done, !(busy_q && done_q), "divider busy and done together")
  `ASSERT_IMPLIES(a_div_rem_bound, busy_q,
                  ({1'b0, rem_q} < ((DIV_N_W+1)'(dvs_q) << (step_q + 1'b1))),
                  "divider remainder out of range")

endmodule

`default_nettype wire

FILE: hdl/pac_resize.sv
// hysteresis decision: grow, shrink or hold the pool from the smoothed utilization
// depends on pac_pkg
`default_nettype none

module pac_resize import pac_pkg::*; (
  input  wire logic [UTIL_W-1:0] avg_i,
  input  wire logic [POOL_W-1:0] cur_i,
  input  wire logic [STB_W-1:0]  stable_i,
  input  wire logic [POOL_W-1:0] min_i,
  input  wire logic [POOL_W-1:0] max_i,
  input  wire logic [UTIL_W-1:0] high_i,
  input  wire logic [UTIL_W-1:0] low_i,
  output resize_t                rs_o
);

  logic [POOL_W+1:0] cur3;
  logic [POOL_W:0]   grow;
  logic [POOL_W-1:0] shrink;
  logic [POOL_W-1:0] nxt;
  logic [STB_W-1:0]  stb;

  assign cur3   = (POOL_W+2)'(cur_i) * (POOL_W+2)'(3);
  assign grow   = cur3[POOL_W+1:1];
  assign shrink = cur3[POOL_W+1:2];

  // candidate size and stability counter
  always_comb begin
    nxt = cur_i;
    stb = stable_i;
    if (avg_i > high_i) begin
      nxt = (grow > (POOL_W+1)'(max_i)) ? max_i : grow[POOL_W-1:0];
      if (nxt != cur_i) begin
        stb = '0;
      end
    end else if (avg_i < low_i) begin
      if (stable_i >= STB_W'(STABLE_NEEDED)) begin
        nxt = (shrink < min_i) ? min_i : shrink;
        if (nxt != cur_i) begin
          stb = '0;
        end
      end else begin
        stb = stable_i + 1'b1;
      end
    end else begin
      stb = (stable_i >= STB_W'(STABLE_CAP)) ? STB_W'(STABLE_CAP) : stable_i + 1'b1;
    end
  end

  // a zero size is refused
  always_comb begin
    rs_o.stable = stb;
    rs_o.pool   = cur_i;
    rs_o.status = ST_UNCHANGED;
    if (nxt != cur_i && nxt != '0) begin
      rs_o.pool   = nxt;
      rs_o.status = (nxt > cur_i) ? ST_GREW : ST_SHRANK;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pool_autoscale_controller_top.sv
// pool autoscale controller top: sequencer, state, config registers, output register
// depends on pac_pkg, pac_div, pac_resize and assert_macros.svh
//
// Usage:
//   s_axis carries one tick request: tdata = {pending_count, now_time} from bit 0.
//   m_axis returns one result per tick: tuser = status, tdata = {measured_util,
//   avg_util, pool_size} from bit 0, padded to 32 bits.
//   cfg carries register writes (index, data) and is always ready; write only
//   while no tick is in flight.
// Sequence:
//   a disabled tick goes straight to the result, a tick that is not due ends after
//   the interval check, and a tick that runs a check computes the utilization,
//   the moving average and the resize decision; the first division is skipped
//   when the utilization saturates. The shared restoring divider is used once
//   for utilization and once for the moving average;
//   s_axis_tready is low while a tick is processed.
// Reset:
//   rst_ni clears the state to the register reset values, the pool to
//   INITIAL_POOL_PAGES and the smoothed utilization to 75.
// Stall:
//   a result waits in the output register; the next tick is taken meanwhile
//   but its result is held until the waiting one has gone.
`default_nettype none
`include "assert_macros.svh"

module pool_autoscale_controller_top import pac_pkg::*; #(
  parameter int unsigned INITIAL_POOL_PAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // tick requests
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [79:0]        s_axis_tdata,   // now_time[63:0], pending_count[79:64]
  // results
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // pool_size[15:0], avg_util[22:16],
                                                  // measured_util[29:23], zero[31:30]
  output logic [2:0]              m_axis_tuser,   // status[2:0]
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [IDX_W-1:0]   cfg_index_i,
  input  wire logic [CDATA_W-1:0] cfg_data_i
);

  localparam int unsigned LIM_W = 36;

  typedef enum logic [3:0] {
    S_IDLE, S_TIME, S_DUE, S_UTIL_PREP, S_UTIL_CHK, S_UTIL_WAIT,
    S_EMA_MUL, S_EMA_SUM, S_EMA_WAIT, S_DECIDE, S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic              en_q;
  logic [POOL_W-1:0] min_q, max_q;
  logic [UTIL_W-1:0] target_q, high_q, low_q, weight_q;
  logic [15:0]       interval_q;

  // controller state
  logic [POOL_W-1:0] pool_q;
  logic [UTIL_W-1:0] avg_q;
  logic [STB_W-1:0]  stable_q;
  logic [TIME_W-1:0] last_q;

  // per-tick working registers
  logic [UTIL_W-1:0] util_q;
  status_e           status_q;
  logic [TIME_W-1:0] now_q, diff_q;
  logic [15:0]       pending_q;
  logic [LIM_W-1:0]  lim_q;
  logic [DIV_N_W-1:0] num_q, ulim_q;
  logic [13:0]       p1_q, p2_q;

  // output register
  logic              m_valid_q;
  logic [31:0]       m_data_q;
  logic [2:0]        m_user_q;

  logic               in_accept;
  logic               out_free;
  logic [UTIL_W-1:0]  alpha, inv_alpha;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num;
  logic [POOL_W-1:0]  div_den;
  logic [DIV_Q_W-1:0] div_quot;
  resize_t            rs;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // sample weight, capped at 100 percent
  assign alpha     = (weight_q > UTIL_W'(PCT)) ? UTIL_W'(PCT) : weight_q;
  assign inv_alpha = UTIL_W'(PCT) - alpha;

  // divider request: utilization quotient, then average divided by 100
  assign div_start = ((state_q == S_UTIL_CHK) && (pool_q != '0) && (num_q < ulim_q)) ||
                     (state_q == S_EMA_SUM);
  assign div_num   = (state_q == S_EMA_SUM) ? DIV_N_W'({1'b0, p1_q} + {1'b0, p2_q}) : num_q;
  assign div_den   = (state_q == S_EMA_SUM) ? POOL_W'(PCT) : pool_q;

  pac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  pac_resize u_resize (
    .avg_i    (avg_q),
    .cur_i    (pool_q),
    .stable_i (stable_q),
    .min_i    (min_q),
    .max_i    (max_q),
    .high_i   (high_q),
    .low_i    (low_q),
    .rs_o     (rs)
  );

  // sequencer, state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      en_q       <= 1'b0;
      min_q      <= POOL_W'(4);
      max_q      <= POOL_W'(1024);
      target_q   <= UTIL_W'(75);
      high_q     <= UTIL_W'(85);
      low_q      <= UTIL_W'(50);
      interval_q <= 16'd1000;
      weight_q   <= UTIL_W'(30);
      pool_q     <= POOL_W'(INITIAL_POOL_PAGES);
      avg_q      <= UTIL_W'(75);
      stable_q   <= '0;
      last_q     <= '0;
      util_q     <= '0;
      status_q   <= ST_DISABLED;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      // the done state loads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end

      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ENABLED: begin
            en_q <= cfg_data_i[0];
            if (cfg_data_i[0]) begin
              avg_q    <= target_q;
              stable_q <= '0;
              last_q   <= '0;
            end
          end
          REG_MIN_PAGES:  min_q      <= cfg_data_i;
          REG_MAX_PAGES:  max_q      <= cfg_data_i;
          REG_TARGET:     target_q   <= cfg_data_i[UTIL_W-1:0];
          REG_HIGH_THR:   high_q     <= cfg_data_i[UTIL_W-1:0];
          REG_LOW_THR:    low_q      <= cfg_data_i[UTIL_W-1:0];
          REG_INTERVAL:   interval_q <= cfg_data_i;
          REG_EMA_WEIGHT: weight_q   <= cfg_data_i[UTIL_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (!en_q) begin
              status_q <= ST_DISABLED;
              util_q   <= '0;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_TIME;
            end
          end
        end
        S_TIME: state_q <= S_DUE;
        // interval check against the scaled limit
        S_DUE: begin
          if (diff_q < TIME_W'(lim_q)) begin
            status_q <= ST_NOT_DUE;
            util_q   <= '0;
            state_q  <= S_DONE;
          end else begin
            last_q  <= now_q;
            state_q <= S_UTIL_PREP;
          end
        end
        S_UTIL_PREP: state_q <= S_UTIL_CHK;
        // zero pool and saturation skip the divider
        S_UTIL_CHK: begin
          if (pool_q == '0) begin
            util_q  <= '0;
            state_q <= S_EMA_MUL;
          end else if (num_q >= ulim_q) begin
            util_q  <= UTIL_W'(PCT);
            state_q <= S_EMA_MUL;
          end else begin
            state_q <= S_UTIL_WAIT;
          end
        end
        S_UTIL_WAIT: begin
          if (div_done) begin
            util_q  <= div_quot;
            state_q <= S_EMA_MUL;
          end
        end
        S_EMA_MUL: state_q <= S_EMA_SUM;
        S_EMA_SUM: state_q <= S_EMA_WAIT;
        S_EMA_WAIT: begin
          if (div_done) begin
            avg_q   <= div_quot;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pool_q   <= rs.pool;
          stable_q <= rs.stable;
          status_q <= rs.status;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, util_q, avg_q, pool_q};
            m_user_q  <= status_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // per-tick datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q     <= s_axis_tdata[63:0];
      pending_q <= s_axis_tdata[79:64];
    end
    if (state_q == S_TIME) begin
      diff_q <= now_q - last_q;
      lim_q  <= LIM_W'(interval_q) * LIM_W'(NS_PER_MS);
    end
    if (state_q == S_UTIL_PREP) begin
      num_q  <= DIV_N_W'(pending_q) * DIV_N_W'(PCT);
      ulim_q <= DIV_N_W'(pool_q) * DIV_N_W'(PCT + 1);
    end
    if (state_q == S_EMA_MUL) begin
      p1_q <= 14'(alpha) * 14'(util_q);
      p2_q <= 14'(inv_alpha) * 14'(avg_q);
    end
  end

  `ASSERT_ALWAYS(a_pool_nonzero, pool_q != '0, "pool size reached zero")
  `ASSERT_ALWAYS(a_stable_cap, stable_q <= STB_W'(STABLE_CAP), "stability counter above cap")
  `ASSERT_IMPLIES(a_div_done_waiting, div_done,
                  (state_q == S_UTIL_WAIT) || (state_q == S_EMA_WAIT),
                  "divider result arrived outside a wait state")

endmodule

`default_nettype wire
